### design/gfp_pkg.sv
// gfp_pkg: shared constants, record descriptor type and helpers
// of the record field parser; no dependencies
`default_nettype none

package gfp_pkg;

	localparam int NAME_MAX_LEN = 31;
	localparam int IDX_W        = $clog2(NAME_MAX_LEN);
	localparam int CNT_W        = $clog2(NAME_MAX_LEN + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int RAM_DEPTH    = QUEUE_DEPTH * (1 << IDX_W);
	localparam int ACC_W        = 11;
	localparam int MAX_W        = 10;
	localparam int CFG_IDX_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_CHAR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LATITUDE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LONGITUDE = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SOUTH = 8'h53;
	localparam logic [7:0] CH_NORTH = 8'h4E;
	localparam logic [7:0] CH_EAST  = 8'h45;
	localparam logic [7:0] CH_WEST  = 8'h57;

	localparam logic [7:0]       SPLIT_RESET   = 8'd9;
	localparam logic [MAX_W-1:0] MAX_AGE_RESET = 10'd120;
	localparam logic [MAX_W-1:0] MAX_LAT_RESET = 10'd90;
	localparam logic [MAX_W-1:0] MAX_LON_RESET = 10'd180;
	localparam logic [ACC_W-1:0] ACC_SAT       = 11'h7FF;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] count;
		logic [9:0]       age;
		logic [10:0]      lat;
		logic [10:0]      lon;
	} rec_t;

	// acc * 10 + digit, saturating
	function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] acc,
			input logic [3:0] digit);
		logic [ACC_W+3:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{ACC_W{1'b0}}, digit};
		return (v > {4'd0, ACC_SAT}) ? ACC_SAT : v[ACC_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] neg11(input logic [ACC_W-1:0] v);
		return {ACC_W{1'b0}} - v;
	endfunction

endpackage

`default_nettype wire

### design/geo_record_field_parser.sv
// geo_record_field_parser: top level, parser front, descriptor queue,
// name ram and replay back end; uses gfp_pkg, gfp_front, gfp_queue, gfp_ram, gfp_back
//
//  channel | signals                              | transaction when
//  --------+--------------------------------------+-------------------------
//  input   | in_valid/in_ready, byte_in           | in_valid && in_ready
//  output  | out_valid/out_ready, name_char..last | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data          | cfg_we high
//
// the front takes one byte per cycle while the descriptor queue has room
// each result passes through a name ram read, then the output register
// the queue holds two records, each owning one bank of the name ram, so the
// front stalls only when both records still await replay
// reset restores the default configuration and clears all control state;
// the name ram is not cleared and needs no clearing pass
`default_nettype none

module geo_record_field_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gfp_pkg::MAX_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    byte_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         name_char,
	output logic [4:0]                         name_len,
	output logic [9:0]                         age,
	output logic signed [10:0]                 latitude,
	output logic signed [10:0]                 longitude,
	output logic                               status,
	output logic                               last
);

	localparam int AW = $clog2(gfp_pkg::RAM_DEPTH);

	logic                      q_full;
	logic                      push;
	gfp_pkg::rec_t             push_rec;
	logic                      pop;
	logic                      head_valid;
	gfp_pkg::rec_t             head;
	logic [gfp_pkg::PTR_W-1:0] wr_ptr;
	logic [gfp_pkg::PTR_W-1:0] rd_ptr;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [7:0]                ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [7:0]                ram_rdata;
	logic [10:0]               lat_bits;
	logic [10:0]               lon_bits;

	gfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.bank      (wr_ptr),
		.push      (push),
		.push_rec  (push_rec),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	gfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.wr_ptr     (wr_ptr),
		.rd_ptr     (rd_ptr)
	);

	gfp_ram #(
		.WIDTH (8),
		.DEPTH (gfp_pkg::RAM_DEPTH)
	) u_name_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.rd_ptr     (rd_ptr),
		.pop        (pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.name_char  (name_char),
		.name_len   (name_len),
		.age        (age),
		.latitude   (lat_bits),
		.longitude  (lon_bits),
		.status     (status),
		.last       (last)
	);

	assign latitude  = signed'(lat_bits);
	assign longitude = signed'(lon_bits);

endmodule

`default_nettype wire

### design/gfp_ram.sv
// gfp_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module gfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/gfp_front.sv
// gfp_front: byte parser with configuration registers; writes name bytes
// into the name ram and pushes one descriptor per record; uses gfp_pkg
`default_nettype none

module gfp_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gfp_pkg::MAX_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      byte_in,
	input  wire logic                            q_full,
	input  wire logic [gfp_pkg::PTR_W-1:0]       bank,
	output logic                                 push,
	output gfp_pkg::rec_t                        push_rec,
	output logic                                 ram_we,
	output logic [$clog2(gfp_pkg::RAM_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                           ram_wdata
);

	localparam logic [2:0] PH_NAME   = 3'd0;
	localparam logic [2:0] PH_AGE    = 3'd1;
	localparam logic [2:0] PH_LAT    = 3'd2;
	localparam logic [2:0] PH_LATSEP = 3'd3;
	localparam logic [2:0] PH_LON    = 3'd4;
	localparam logic [2:0] PH_END    = 3'd5;
	localparam logic [2:0] PH_ERR    = 3'd6;

	logic [7:0]                   split_q;
	logic [gfp_pkg::MAX_W-1:0]    max_age_q;
	logic [gfp_pkg::MAX_W-1:0]    max_lat_q;
	logic [gfp_pkg::MAX_W-1:0]    max_lon_q;
	logic [2:0]                   phase_q;
	logic                         digit_seen_q;
	logic [gfp_pkg::ACC_W-1:0]    age_q;
	logic [gfp_pkg::ACC_W-1:0]    lat_q;
	logic                         lat_neg_q;
	logic [gfp_pkg::ACC_W-1:0]    lon_q;
	logic [gfp_pkg::CNT_W-1:0]    count_q;

	logic                         accept;
	logic                         is_digit;
	logic                         is_split;
	logic                         is_end;
	logic                         name_full;
	logic [3:0]                   digit_val;
	logic                         ok;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_digit  = (byte_in >= gfp_pkg::CH_ZERO) && (byte_in <= gfp_pkg::CH_NINE);
	assign digit_val = 4'(byte_in - gfp_pkg::CH_ZERO);
	assign is_split  = (byte_in == split_q);
	assign is_end    = (byte_in == gfp_pkg::CH_NUL);
	assign name_full = (count_q >= gfp_pkg::CNT_W'(gfp_pkg::NAME_MAX_LEN));
	assign ok        = (phase_q == PH_END);

	assign push = accept && is_end;
	always_comb begin
		push_rec.status = !ok;
		push_rec.count  = ok ? count_q : '0;
		push_rec.age    = ok ? age_q[9:0] : '0;
		push_rec.lat    = ok ? (lat_neg_q ? gfp_pkg::neg11(lat_q) : lat_q) : '0;
		push_rec.lon    = ok ? lon_q : '0;
	end

	// name bytes go to the bank of the queue slot this record will take
	assign ram_we    = accept && !is_end && (phase_q == PH_NAME) && !is_split && !name_full;
	assign ram_waddr = {bank, count_q[gfp_pkg::IDX_W-1:0]};
	assign ram_wdata = byte_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q   <= gfp_pkg::SPLIT_RESET;
			max_age_q <= gfp_pkg::MAX_AGE_RESET;
			max_lat_q <= gfp_pkg::MAX_LAT_RESET;
			max_lon_q <= gfp_pkg::MAX_LON_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gfp_pkg::REG_SPLIT_CHAR:    split_q   <= cfg_data[7:0];
				gfp_pkg::REG_MAX_AGE:       max_age_q <= cfg_data;
				gfp_pkg::REG_MAX_LATITUDE:  max_lat_q <= cfg_data;
				gfp_pkg::REG_MAX_LONGITUDE: max_lon_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_NAME;
			digit_seen_q <= 1'b0;
			age_q        <= '0;
			lat_q        <= '0;
			lat_neg_q    <= 1'b0;
			lon_q        <= '0;
			count_q      <= '0;
		end else if (accept) begin
			if (is_end) begin
				phase_q      <= PH_NAME;
				digit_seen_q <= 1'b0;
				age_q        <= '0;
				lat_q        <= '0;
				lat_neg_q    <= 1'b0;
				lon_q        <= '0;
				count_q      <= '0;
			end else begin
				unique case (phase_q)
					PH_NAME: begin
						if (is_split) begin
							phase_q      <= (count_q == '0) ? PH_ERR : PH_AGE;
							digit_seen_q <= 1'b0;
						end else if (name_full) begin
							phase_q <= PH_ERR;
						end else begin
							count_q <= count_q + gfp_pkg::CNT_W'(1);
						end
					end
					PH_AGE: begin
						if (is_digit) begin
							age_q        <= gfp_pkg::acc_add(age_q, digit_val);
							digit_seen_q <= 1'b1;
						end else if (is_split && digit_seen_q && age_q <= {1'b0, max_age_q}) begin
							phase_q      <= PH_LAT;
							digit_seen_q <= 1'b0;
						end else begin
							phase_q <= PH_ERR;
						end
					end
					PH_LAT: begin
						if (is_digit) begin
							lat_q        <= gfp_pkg::acc_add(lat_q, digit_val);
							digit_seen_q <= 1'b1;
						end else if ((byte_in == gfp_pkg::CH_SOUTH || byte_in == gfp_pkg::CH_NORTH)
								&& digit_seen_q && lat_q <= {1'b0, max_lat_q}) begin
							lat_neg_q    <= (byte_in == gfp_pkg::CH_NORTH);
							phase_q      <= PH_LATSEP;
							digit_seen_q <= 1'b0;
						end else begin
							phase_q <= PH_ERR;
						end
					end
					PH_LATSEP: begin
						phase_q <= is_split ? PH_LON : PH_ERR;
					end
					PH_LON: begin
						if (is_digit) begin
							lon_q        <= gfp_pkg::acc_add(lon_q, digit_val);
							digit_seen_q <= 1'b1;
						end else if ((byte_in == gfp_pkg::CH_EAST || byte_in == gfp_pkg::CH_WEST)
								&& digit_seen_q && lon_q <= {1'b0, max_lon_q}) begin
							if (byte_in == gfp_pkg::CH_WEST) begin
								lon_q <= gfp_pkg::neg11(lon_q);
							end
							phase_q      <= PH_END;
							digit_seen_q <= 1'b0;
						end else begin
							phase_q <= PH_ERR;
						end
					end
					default: begin
						phase_q <= PH_ERR;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### design/gfp_queue.sv
// gfp_queue: short queue of finished record descriptors; a slot is freed
// only once the last name ram read of its run has returned; uses gfp_pkg
`default_nettype none

module gfp_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire gfp_pkg::rec_t             push_rec,
	input  wire logic                      pop,
	output logic                           full,
	output logic                           head_valid,
	output gfp_pkg::rec_t                  head,
	output logic [gfp_pkg::PTR_W-1:0]      wr_ptr,
	output logic [gfp_pkg::PTR_W-1:0]      rd_ptr
);

	localparam int CNT_QW = $clog2(gfp_pkg::QUEUE_DEPTH + 1);

	gfp_pkg::rec_t          slot_q [gfp_pkg::QUEUE_DEPTH];
	logic [gfp_pkg::PTR_W-1:0] wr_q;
	logic [gfp_pkg::PTR_W-1:0] rd_q;
	logic [CNT_QW-1:0]         fill_q;

	assign full       = (fill_q == CNT_QW'(gfp_pkg::QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_q];
	assign wr_ptr     = wr_q;
	assign rd_ptr     = rd_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + gfp_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + gfp_pkg::PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_QW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_QW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("descriptor pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !head_valid))
		else $error("descriptor popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_q == rd_q))
		else $error("queue pointers disagree while empty");

endmodule

`default_nettype wire

### design/gfp_back.sv
// gfp_back: replays the head record's name bytes from the name ram into
// the output register, numbers on the last result; uses gfp_pkg
`default_nettype none

module gfp_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             head_valid,
	input  wire gfp_pkg::rec_t                    head,
	input  wire logic [gfp_pkg::PTR_W-1:0]        rd_ptr,
	output logic                                  pop,
	output logic                                  ram_re,
	output logic [$clog2(gfp_pkg::RAM_DEPTH)-1:0] ram_raddr,
	input  wire logic [7:0]                       ram_rdata,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            name_char,
	output logic [4:0]                            name_len,
	output logic [9:0]                            age,
	output logic [10:0]                           latitude,
	output logic [10:0]                           longitude,
	output logic                                  status,
	output logic                                  last
);

	logic                      rd_pend_q;
	logic [gfp_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic                      fin;

	// one read in flight at a time, issued only if the output slot frees up
	assign ram_re    = head_valid && !rd_pend_q && (!out_valid_q || out_ready);
	assign ram_raddr = {rd_ptr, idx_q};
	assign fin       = head.status
		|| ((gfp_pkg::CNT_W'(idx_q) + gfp_pkg::CNT_W'(1)) == head.count);
	assign pop       = rd_pend_q && fin;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= ram_re;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= fin ? '0 : idx_q + gfp_pkg::IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			name_char <= head.status ? 8'd0 : ram_rdata;
			name_len  <= 5'(head.count);
			age       <= fin ? head.age : '0;
			latitude  <= fin ? head.lat : '0;
			longitude <= fin ? head.lon : '0;
			status    <= head.status;
			last      <= fin;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (!out_valid_q && head_valid))
		else $error("read data returned with no free output slot or no record");

endmodule

`default_nettype wire
